// ===== design/rail_frame_cross_section_defines.svh =====
// assertion macros for the rail frame cross-section block
`ifndef RAIL_FRAME_CROSS_SECTION_DEFINES_SVH
`define RAIL_FRAME_CROSS_SECTION_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FRCS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("frcs assertion failed");
`define FRCS_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("frcs assertion failed");
`else
`define FRCS_ASSERT(lbl, clk, rstn, prop)
`define FRCS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== design/frcs_pkg.sv =====
// shared types, constants and helpers of the rail frame cross-section block
package frcs_pkg;
	localparam int POS_W = 32;
	localparam int VEC_W = 16;
	localparam int FRAC_W = VEC_W - 2;
	localparam int CFG_W = 20;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1311);
	localparam int CROSS_W = 2 * VEC_W + 1;
	localparam int NRM_BITS = 24;
	localparam int SQ_W = 2 * NRM_BITS + 2;
	localparam int LEN_W = NRM_BITS + 2;
	localparam int NUM_W = NRM_BITS + FRAC_W + 1;
	localparam int DCNT_W = $clog2(VEC_W);
	localparam int MAG_W = VEC_W + 1;
	localparam int CPROD_W = MAG_W + CFG_W;
	localparam int OFF_W = CPROD_W + 1 - FRAC_W;
	localparam int SUM_W = ((POS_W > OFF_W) ? POS_W : OFF_W) + 2;
	localparam int IN_DATA_W = ((3 * POS_W + 3 * VEC_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((3 * POS_W + 6 * VEC_W + 7) / 8) * 8;
	localparam logic [1:0] CORNER_LAST = 2'd3;
	localparam logic [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};

	typedef logic signed [VEC_W-1:0] vec_t;
	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [CROSS_W-1:0] cross_t;

	typedef struct packed {
		vec_t tan_z;
		vec_t tan_y;
		vec_t tan_x;
		pos_t pos_z;
		pos_t pos_y;
		pos_t pos_x;
	} item_t;

	typedef struct packed {
		vec_t binorm_z;
		vec_t binorm_y;
		vec_t binorm_x;
		vec_t norm_z;
		vec_t norm_y;
		vec_t norm_x;
		pos_t vertex_z;
		pos_t vertex_y;
		pos_t vertex_x;
	} out_word_t;

	typedef struct packed {
		logic   start;
		cross_t vz;
		cross_t vy;
		cross_t vx;
	} norm_req_t;

	typedef struct packed {
		logic done;
		vec_t rz;
		vec_t ry;
		vec_t rx;
	} norm_rsp_t;

	typedef enum logic [2:0] {
		N_IDLE, N_SHIFT, N_SQ, N_ROOT, N_DIVLD, N_DIV, N_DONE
	} norm_state_t;

	typedef enum logic [3:0] {
		C_IDLE, C_XN, C_NS, C_NW, C_XB, C_BS, C_BW, C_CK, C_CO
	} core_state_t;

	// operand picks of the six cross product terms, first vector
	function automatic logic [1:0] xa_idx(logic [2:0] k);
		logic [1:0] r;
		unique case (k)
			3'd0: r = 2'd1;
			3'd1: r = 2'd2;
			3'd2: r = 2'd2;
			3'd3: r = 2'd0;
			3'd4: r = 2'd0;
			3'd5: r = 2'd1;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	// operand picks of the six cross product terms, second vector
	function automatic logic [1:0] xb_idx(logic [2:0] k);
		logic [1:0] r;
		unique case (k)
			3'd0: r = 2'd2;
			3'd1: r = 2'd1;
			3'd2: r = 2'd0;
			3'd3: r = 2'd2;
			3'd4: r = 2'd1;
			3'd5: r = 2'd0;
			default: r = 2'd0;
		endcase
		return r;
	endfunction
endpackage

// ===== design/frcs_queue.sv =====
// two-entry sample queue between the stream input and the frame engine
module frcs_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  frcs_pkg::item_t              in_item,
	input  logic                         pop,
	output logic                         avail,
	output frcs_pkg::item_t              head
);
	frcs_pkg::item_t slot_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign avail = (cnt_q != 2'd0);
	assign head = slot_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= in_item;
	end
endmodule

// ===== design/frcs_norm.sv =====
// multi-cycle vector normalizer: bit shifts, squares, bit-serial root and divide
module frcs_norm (
	input  logic                clk,
	input  logic                arst_n,
	input  frcs_pkg::norm_req_t req,
	output frcs_pkg::norm_rsp_t rsp
);
	frcs_pkg::norm_state_t state_q, state_d;
	logic [frcs_pkg::CROSS_W-1:0] m_q [3];
	logic [frcs_pkg::CROSS_W-1:0] mx_q;
	logic neg_q [3];
	logic [frcs_pkg::SQ_W-1:0] sq_q, root_q, bit_q;
	logic [2*frcs_pkg::NRM_BITS-1:0] prod_q;
	logic [1:0] cnt_q, comp_q;
	logic [frcs_pkg::LEN_W-1:0] len_q, rem_q;
	logic [frcs_pkg::VEC_W-1:0] nb_q, quo_q;
	logic [frcs_pkg::DCNT_W-1:0] dcnt_q;
	frcs_pkg::vec_t res_q [3];

	frcs_pkg::cross_t vin [3];
	logic [frcs_pkg::CROSS_W-1:0] mag [3];
	logic [frcs_pkg::CROSS_W-1:0] mx_in;
	logic big;
	logic [frcs_pkg::SQ_W-1:0] sum_rb, root_d;
	logic [frcs_pkg::NUM_W-1:0] num;
	logic [frcs_pkg::LEN_W:0] trial;
	logic ge;
	logic [frcs_pkg::LEN_W-1:0] rem_d;
	logic [frcs_pkg::VEC_W-1:0] quo_d, u;

	assign vin[0] = req.vx;
	assign vin[1] = req.vy;
	assign vin[2] = req.vz;

	// magnitudes and largest magnitude of the incoming vector
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = vin[i][frcs_pkg::CROSS_W-1] ? -vin[i] : vin[i];
		end
		mx_in = mag[0];
		if (mag[1] > mx_in) mx_in = mag[1];
		if (mag[2] > mx_in) mx_in = mag[2];
	end

	// datapath helpers
	always_comb begin
		big = |mx_q[frcs_pkg::CROSS_W-1:frcs_pkg::NRM_BITS];
		sum_rb = root_q + bit_q;
		root_d = (sq_q >= sum_rb) ? (root_q >> 1) + bit_q : root_q >> 1;
		num = (frcs_pkg::NUM_W'(m_q[comp_q][frcs_pkg::NRM_BITS-1:0]) << frcs_pkg::FRAC_W)
			+ frcs_pkg::NUM_W'(len_q >> 1);
		trial = {rem_q, nb_q[frcs_pkg::VEC_W-1]};
		ge = trial >= {1'b0, len_q};
		rem_d = ge ? frcs_pkg::LEN_W'(trial - {1'b0, len_q}) : frcs_pkg::LEN_W'(trial);
		quo_d = {quo_q[frcs_pkg::VEC_W-2:0], ge};
		u = quo_d[frcs_pkg::VEC_W-1] ? frcs_pkg::VEC_MAX : quo_d;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= frcs_pkg::N_IDLE;
		else state_q <= state_d;
	end

	// next state and response
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			frcs_pkg::N_IDLE: begin
				if (req.start) state_d = (mx_in == '0) ? frcs_pkg::N_DONE : frcs_pkg::N_SHIFT;
			end
			frcs_pkg::N_SHIFT: begin
				if (!big && mx_q[frcs_pkg::NRM_BITS-1]) state_d = frcs_pkg::N_SQ;
			end
			frcs_pkg::N_SQ: begin
				if (cnt_q == 2'd3) state_d = frcs_pkg::N_ROOT;
			end
			frcs_pkg::N_ROOT: begin
				if (bit_q[0]) state_d = frcs_pkg::N_DIVLD;
			end
			frcs_pkg::N_DIVLD: state_d = frcs_pkg::N_DIV;
			frcs_pkg::N_DIV: begin
				if (dcnt_q == frcs_pkg::DCNT_W'(frcs_pkg::VEC_W - 1))
					state_d = (comp_q == 2'd2) ? frcs_pkg::N_DONE : frcs_pkg::N_DIVLD;
			end
			frcs_pkg::N_DONE: state_d = frcs_pkg::N_IDLE;
			default: state_d = frcs_pkg::N_IDLE;
		endcase
		rsp.done = (state_q == frcs_pkg::N_DONE);
		rsp.rx = res_q[0];
		rsp.ry = res_q[1];
		rsp.rz = res_q[2];
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			frcs_pkg::N_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i] <= mag[i];
					neg_q[i] <= vin[i][frcs_pkg::CROSS_W-1];
					res_q[i] <= '0;
				end
				mx_q <= mx_in;
			end
			frcs_pkg::N_SHIFT: begin
				// bring the largest magnitude into the working octave
				if (big) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
					mx_q <= mx_q >> 1;
				end else if (!mx_q[frcs_pkg::NRM_BITS-1]) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
					mx_q <= mx_q << 1;
				end
				cnt_q <= 2'd0;
				sq_q <= '0;
			end
			frcs_pkg::N_SQ: begin
				// one square per cycle; each product is registered, then added to the sum
				if (cnt_q != 2'd0) sq_q <= sq_q + frcs_pkg::SQ_W'(prod_q);
				if (cnt_q != 2'd3)
					prod_q <= m_q[cnt_q][frcs_pkg::NRM_BITS-1:0]
						* m_q[cnt_q][frcs_pkg::NRM_BITS-1:0];
				cnt_q <= 2'(cnt_q + 2'd1);
				root_q <= '0;
				bit_q <= frcs_pkg::SQ_W'(1) << (frcs_pkg::SQ_W - 2);
			end
			frcs_pkg::N_ROOT: begin
				// one root bit per cycle
				if (sq_q >= sum_rb) sq_q <= sq_q - sum_rb;
				root_q <= root_d;
				bit_q <= bit_q >> 2;
				len_q <= frcs_pkg::LEN_W'(root_d);
				comp_q <= 2'd0;
			end
			frcs_pkg::N_DIVLD: begin
				rem_q <= frcs_pkg::LEN_W'(num[frcs_pkg::NUM_W-1:frcs_pkg::VEC_W]);
				nb_q <= num[frcs_pkg::VEC_W-1:0];
				quo_q <= '0;
				dcnt_q <= '0;
			end
			frcs_pkg::N_DIV: begin
				// one quotient bit per cycle, clamp and sign on the last
				rem_q <= rem_d;
				nb_q <= nb_q << 1;
				quo_q <= quo_d;
				dcnt_q <= frcs_pkg::DCNT_W'(dcnt_q + 1'b1);
				if (dcnt_q == frcs_pkg::DCNT_W'(frcs_pkg::VEC_W - 1)) begin
					res_q[comp_q] <= neg_q[comp_q] ? -$signed(u) : $signed(u);
					comp_q <= 2'(comp_q + 2'd1);
				end
			end
			frcs_pkg::N_DONE: begin
			end
			default: begin
			end
		endcase
	end
endmodule

// ===== design/frcs_core.sv =====
// frame engine: cross products, two normalizations, frame state and the four corners
module frcs_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         avail,
	input  frcs_pkg::item_t              head,
	output logic                         pop,
	input  logic [frcs_pkg::CFG_W-1:0]   half_width,
	output frcs_pkg::norm_req_t          nreq,
	input  frcs_pkg::norm_rsp_t          nrsp,
	output logic                         out_valid,
	input  logic                         out_ready,
	output frcs_pkg::out_word_t          out_word,
	output logic [1:0]                   out_corner,
	output logic                         out_last
);
	frcs_pkg::core_state_t state_q, state_d;
	logic have_frame_q;
	frcs_pkg::vec_t prevb_q [3], tan_q [3], n_q [3], b_q [3];
	frcs_pkg::pos_t pos_q [3], vtx_q [3];
	frcs_pkg::cross_t acc_q [3];
	logic [2:0] xk_q;
	logic signed [2*frcs_pkg::VEC_W-1:0] prod_q;
	logic [1:0] k_q, cc_q;
	logic [frcs_pkg::CPROD_W-1:0] cprod_q;
	logic cneg_q;
	logic oval_q;
	frcs_pkg::out_word_t ow_q;
	logic [1:0] ocorner_q;
	logic olast_q;

	frcs_pkg::vec_t ht [3];
	logic signed [frcs_pkg::VEC_W:0] d [3];
	frcs_pkg::vec_t opa, opb;
	logic [2:0] xj;
	logic sn, sb;
	logic signed [frcs_pkg::VEC_W:0] cn, cb, cs;
	logic [frcs_pkg::MAG_W-1:0] cmag;
	logic [frcs_pkg::CPROD_W:0] rnd;
	logic signed [frcs_pkg::SUM_W-1:0] off, psum;
	frcs_pkg::pos_t sat;
	logic [1:0] ci, cm;
	logic load;

	assign ht[0] = head.tan_x;
	assign ht[1] = head.tan_y;
	assign ht[2] = head.tan_z;

	// seed difference vector: t x (1,1,1)
	always_comb begin
		d[0] = (frcs_pkg::VEC_W+1)'(ht[1]) - (frcs_pkg::VEC_W+1)'(ht[2]);
		d[1] = (frcs_pkg::VEC_W+1)'(ht[2]) - (frcs_pkg::VEC_W+1)'(ht[0]);
		d[2] = (frcs_pkg::VEC_W+1)'(ht[0]) - (frcs_pkg::VEC_W+1)'(ht[1]);
	end

	// cross product operand selection
	always_comb begin
		if (state_q == frcs_pkg::C_XN) begin
			opa = prevb_q[frcs_pkg::xa_idx(xk_q)];
			opb = tan_q[frcs_pkg::xb_idx(xk_q)];
		end else begin
			opa = tan_q[frcs_pkg::xa_idx(xk_q)];
			opb = n_q[frcs_pkg::xb_idx(xk_q)];
		end
		xj = 3'(xk_q - 3'd1);
	end

	// corner offset terms
	always_comb begin
		sn = (k_q == 2'd1) || (k_q == 2'd2);
		sb = (k_q == 2'd0) || (k_q == 2'd1);
		cm = (cc_q == 2'd3) ? 2'd2 : cc_q;
		cn = sn ? (frcs_pkg::VEC_W+1)'(n_q[cm]) : -(frcs_pkg::VEC_W+1)'(n_q[cm]);
		cb = sb ? (frcs_pkg::VEC_W+1)'(b_q[cm]) : -(frcs_pkg::VEC_W+1)'(b_q[cm]);
		cs = cn + cb;
		cmag = cs[frcs_pkg::VEC_W] ? frcs_pkg::MAG_W'(-cs) : frcs_pkg::MAG_W'(cs);
		ci = 2'(cc_q - 2'd1);
		rnd = (frcs_pkg::CPROD_W+1)'(cprod_q)
			+ (frcs_pkg::CPROD_W+1)'(1 << (frcs_pkg::FRAC_W - 1));
		off = frcs_pkg::SUM_W'($signed({1'b0, rnd[frcs_pkg::CPROD_W:frcs_pkg::FRAC_W]}));
		psum = cneg_q ? frcs_pkg::SUM_W'(pos_q[ci]) - off : frcs_pkg::SUM_W'(pos_q[ci]) + off;
		if (psum > $signed(frcs_pkg::SUM_W'({1'b0, {(frcs_pkg::POS_W-1){1'b1}}})))
			sat = {1'b0, {(frcs_pkg::POS_W-1){1'b1}}};
		else if (psum < -$signed(frcs_pkg::SUM_W'({1'b0, {(frcs_pkg::POS_W-1){1'b1}}})) - 1)
			sat = {1'b1, {(frcs_pkg::POS_W-1){1'b0}}};
		else
			sat = frcs_pkg::POS_W'(psum);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= frcs_pkg::C_IDLE;
		else state_q <= state_d;
	end

	// next state and handshake outputs
	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		load = 1'b0;
		nreq.start = 1'b0;
		nreq.vx = acc_q[0];
		nreq.vy = acc_q[1];
		nreq.vz = acc_q[2];
		unique case (state_q)
			frcs_pkg::C_IDLE: begin
				if (avail) begin
					pop = 1'b1;
					state_d = have_frame_q ? frcs_pkg::C_XN : frcs_pkg::C_NS;
				end
			end
			frcs_pkg::C_XN: if (xk_q == 3'd6) state_d = frcs_pkg::C_NS;
			frcs_pkg::C_NS: begin
				nreq.start = 1'b1;
				state_d = frcs_pkg::C_NW;
			end
			frcs_pkg::C_NW: if (nrsp.done) state_d = frcs_pkg::C_XB;
			frcs_pkg::C_XB: if (xk_q == 3'd6) state_d = frcs_pkg::C_BS;
			frcs_pkg::C_BS: begin
				nreq.start = 1'b1;
				state_d = frcs_pkg::C_BW;
			end
			frcs_pkg::C_BW: if (nrsp.done) state_d = frcs_pkg::C_CK;
			frcs_pkg::C_CK: if (cc_q == 2'd3) state_d = frcs_pkg::C_CO;
			frcs_pkg::C_CO: begin
				if (!oval_q || out_ready) begin
					load = 1'b1;
					state_d = (k_q == frcs_pkg::CORNER_LAST) ? frcs_pkg::C_IDLE : frcs_pkg::C_CK;
				end
			end
			default: state_d = frcs_pkg::C_IDLE;
		endcase
	end

	// frame state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_frame_q <= 1'b0;
			for (int i = 0; i < 3; i++) prevb_q[i] <= '0;
			oval_q <= 1'b0;
		end else begin
			if (state_q == frcs_pkg::C_BW && nrsp.done) begin
				prevb_q[0] <= nrsp.rx;
				prevb_q[1] <= nrsp.ry;
				prevb_q[2] <= nrsp.rz;
				have_frame_q <= (nrsp.rx != '0) || (nrsp.ry != '0) || (nrsp.rz != '0);
			end
			if (load) oval_q <= 1'b1;
			else if (out_ready) oval_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		// sample capture and seed vector
		if (pop) begin
			pos_q[0] <= head.pos_x;
			pos_q[1] <= head.pos_y;
			pos_q[2] <= head.pos_z;
			for (int i = 0; i < 3; i++) tan_q[i] <= ht[i];
			if ((d[0] != '0) || (d[1] != '0) || (d[2] != '0)) begin
				for (int i = 0; i < 3; i++) acc_q[i] <= frcs_pkg::CROSS_W'(d[i]);
			end else begin
				acc_q[0] <= -frcs_pkg::CROSS_W'(ht[2]);
				acc_q[1] <= '0;
				acc_q[2] <= frcs_pkg::CROSS_W'(ht[0]);
			end
		end
		if (state_q == frcs_pkg::C_IDLE || state_q == frcs_pkg::C_NW) xk_q <= '0;
		// cross product: one product per cycle; each product is registered, then folded into its component
		if (state_q == frcs_pkg::C_XN || state_q == frcs_pkg::C_XB) begin
			if (xk_q != 3'd6) prod_q <= opa * opb;
			if (xk_q != 3'd0) begin
				if (!xj[0]) acc_q[xj[2:1]] <= frcs_pkg::CROSS_W'(prod_q);
				else acc_q[xj[2:1]] <= acc_q[xj[2:1]] - frcs_pkg::CROSS_W'(prod_q);
			end
			xk_q <= 3'(xk_q + 3'd1);
		end
		if (state_q == frcs_pkg::C_NW && nrsp.done) begin
			n_q[0] <= nrsp.rx;
			n_q[1] <= nrsp.ry;
			n_q[2] <= nrsp.rz;
		end
		if (state_q == frcs_pkg::C_BW && nrsp.done) begin
			b_q[0] <= nrsp.rx;
			b_q[1] <= nrsp.ry;
			b_q[2] <= nrsp.rz;
			k_q <= 2'd0;
			cc_q <= 2'd0;
		end
		// corner: offset product per component is registered, then added with saturation
		if (state_q == frcs_pkg::C_CK) begin
			if (cc_q != 2'd3) begin
				cprod_q <= frcs_pkg::CPROD_W'(cmag) * frcs_pkg::CPROD_W'(half_width);
				cneg_q <= cs[frcs_pkg::VEC_W];
			end
			if (cc_q != 2'd0) vtx_q[ci] <= sat;
			cc_q <= 2'(cc_q + 2'd1);
		end
		if (load) begin
			ow_q.vertex_x <= vtx_q[0];
			ow_q.vertex_y <= vtx_q[1];
			ow_q.vertex_z <= vtx_q[2];
			ow_q.norm_x <= n_q[0];
			ow_q.norm_y <= n_q[1];
			ow_q.norm_z <= n_q[2];
			ow_q.binorm_x <= b_q[0];
			ow_q.binorm_y <= b_q[1];
			ow_q.binorm_z <= b_q[2];
			ocorner_q <= k_q;
			olast_q <= (k_q == frcs_pkg::CORNER_LAST);
			k_q <= 2'(k_q + 2'd1);
			cc_q <= 2'd0;
		end
	end

	assign out_valid = oval_q;
	assign out_word = ow_q;
	assign out_corner = ocorner_q;
	assign out_last = olast_q;
endmodule

// ===== design/rail_frame_cross_section.sv =====
// Rail cross-section generator with a propagated curve frame.
// Input stream s_axis: one curve sample per word, position (Q16.16) and tangent (Q2.14).
// Output stream m_axis: four words per sample, the square rail corners p + a*(+/-n +/- b)
// in order -n+b, n+b, n-b, -n-b, each with the sample's normal and binormal; tlast marks
// the fourth corner, tuser carries the corner number.
// cfg channel: writes the half width a (unsigned Q4.16); write only while idle.
// Samples wait in a two-word queue, so the input keeps accepting while the engine works.
// Per sample the engine runs two normalizations, each a bit-at-a-time shift into range,
// three squares, a 25-step root and three 16-step divides, plus a cross product with the
// previous binormal (when a frame is held), one for the binormal and the four corners.
// A new sample starts as soon as the previous one's last corner is loaded into the output
// register. Reset clears the frame, so the first sample after reset builds a fresh frame,
// and sets the half width to about 0.02. A stalled receiver holds the output word; the
// engine waits for it and the queue fills, after which s_axis_tready drops.
`include "rail_frame_cross_section_defines.svh"
module rail_frame_cross_section (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// pos_x, pos_y, pos_z, tan_x, tan_y, tan_z
	input  logic [frcs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// vertex_x, vertex_y, vertex_z, norm_x, norm_y, norm_z, binorm_x, binorm_y, binorm_z
	output logic [frcs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// corner
	output logic [1:0]                       m_axis_tuser,
	output logic                             m_axis_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [frcs_pkg::CFG_W-1:0]       cfg_data
);
	logic [frcs_pkg::CFG_W-1:0] half_width_q;
	logic avail, pop;
	frcs_pkg::item_t head;
	frcs_pkg::norm_req_t nreq;
	frcs_pkg::norm_rsp_t nrsp;
	frcs_pkg::out_word_t ow;

	// half width register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) half_width_q <= frcs_pkg::CFG_RESET;
		else if (cfg_valid) half_width_q <= cfg_data;
	end

	frcs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (frcs_pkg::item_t'(s_axis_tdata[$bits(frcs_pkg::item_t)-1:0])),
		.pop      (pop),
		.avail    (avail),
		.head     (head)
	);

	frcs_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (nreq),
		.rsp    (nrsp)
	);

	frcs_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.avail      (avail),
		.head       (head),
		.pop        (pop),
		.half_width (half_width_q),
		.nreq       (nreq),
		.nrsp       (nrsp),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_word   (ow),
		.out_corner (m_axis_tuser),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = frcs_pkg::OUT_DATA_W'(ow);

	// last word of a sample is always the fourth corner
	`FRCS_ASSERT_ALWAYS(a_last_corner, clk,
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == frcs_pkg::CORNER_LAST))
	// corners follow each other in order
	`FRCS_ASSERT(a_corner_order, clk, arst_n,
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
		(!m_axis_tvalid || (m_axis_tuser == 2'($past(m_axis_tuser) + 2'd1))))
endmodule

// ===== tb/tb_rail_frame_cross_section.sv =====
// self-checking testbench for the rail frame cross-section block
module tb_rail_frame_cross_section;
	typedef logic [2:0][63:0] tri_t;
	typedef struct packed {
		frcs_pkg::out_word_t w;
		logic [1:0]          k;
		logic                l;
	} corner_word_t;

	localparam int LIMIT_CYC = 600000;
	localparam int SETTLE_CYC = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [frcs_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [frcs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [frcs_pkg::CFG_W-1:0] cfg_data = '0;

	rail_frame_cross_section i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// frame state of the predictor
	logic [frcs_pkg::CFG_W-1:0] half_width = frcs_pkg::CFG_RESET;
	logic frame_valid = 1'b0;
	tri_t last_binorm = '0;

	frcs_pkg::item_t sample_q[$];
	corner_word_t corner_q[$];
	logic in_fire = 1'b0;
	int cyc = 0;
	int errors = 0;
	int samples_in = 0;
	int corners_seen = 0;
	int stall_left = 0;
	logic calm = 1'b0;
	logic hold_go = 1'b0;
	logic held = 1'b0;

	// integer square root, bit by bit
	function automatic logic [63:0] isqrt(logic [63:0] q);
		logic [63:0] r, bt;
		r = 0;
		bt = 64'd1 << 62;
		while (bt > q) bt = bt >> 2;
		while (bt != 0) begin
			if (q >= r + bt) begin
				q = q - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	// scale a vector to unit length in Q2.14
	function automatic tri_t unit3(tri_t v);
		tri_t m, r;
		logic [2:0] ng;
		logic [63:0] mx, q, len, u;
		longint c;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			c = $signed(v[i]);
			ng[i] = c < 0;
			m[i] = ng[i] ? -c : c;
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) return '0;
		while (mx >= (64'd1 << 24)) begin
			mx = mx >> 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
		end
		while (mx < (64'd1 << 23)) begin
			mx = mx << 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
		end
		q = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = isqrt(q);
		for (int i = 0; i < 3; i++) begin
			u = ((m[i] << frcs_pkg::FRAC_W) + (len >> 1)) / len;
			if (u > 64'(frcs_pkg::VEC_MAX)) u = 64'(frcs_pkg::VEC_MAX);
			r[i] = ng[i] ? -u : u;
		end
		return r;
	endfunction

	function automatic tri_t cross3(tri_t a, tri_t b);
		tri_t r;
		r[0] = $signed(a[1]) * $signed(b[2]) - $signed(a[2]) * $signed(b[1]);
		r[1] = $signed(a[2]) * $signed(b[0]) - $signed(a[0]) * $signed(b[2]);
		r[2] = $signed(a[0]) * $signed(b[1]) - $signed(a[1]) * $signed(b[0]);
		return r;
	endfunction

	// frame update and the four rail corners of one sample
	task automatic frame_corners(frcs_pkg::item_t it);
		tri_t t, p, tmp, n, b;
		longint s, off, sum, sn, sb;
		logic [63:0] mag;
		corner_word_t cw;
		t[0] = longint'(it.tan_x); t[1] = longint'(it.tan_y); t[2] = longint'(it.tan_z);
		p[0] = longint'(it.pos_x); p[1] = longint'(it.pos_y); p[2] = longint'(it.pos_z);
		if (!frame_valid) begin
			tmp[0] = $signed(t[1]) - $signed(t[2]);
			tmp[1] = $signed(t[2]) - $signed(t[0]);
			tmp[2] = $signed(t[0]) - $signed(t[1]);
			// tangent along (1,1,1): fall back to the y axis
			if (tmp == '0) begin
				tmp[0] = -$signed(t[2]);
				tmp[1] = 0;
				tmp[2] = t[0];
			end
		end else begin
			tmp = cross3(last_binorm, t);
		end
		n = unit3(tmp);
		b = unit3(cross3(t, n));
		last_binorm = b;
		frame_valid = (b != '0);
		for (int k = 0; k < 4; k++) begin
			sn = (k == 1 || k == 2) ? 1 : -1;
			sb = (k == 0 || k == 1) ? 1 : -1;
			for (int i = 0; i < 3; i++) begin
				s = sn * $signed(n[i]) + sb * $signed(b[i]);
				mag = (s < 0) ? -s : s;
				off = (mag * half_width + (64'd1 << (frcs_pkg::FRAC_W - 1))) >> frcs_pkg::FRAC_W;
				sum = (s < 0) ? $signed(p[i]) - off : $signed(p[i]) + off;
				if (sum > 64'sd2147483647) sum = 64'sd2147483647;
				if (sum < -64'sd2147483648) sum = -64'sd2147483648;
				case (i)
					0: cw.w.vertex_x = sum[31:0];
					1: cw.w.vertex_y = sum[31:0];
					default: cw.w.vertex_z = sum[31:0];
				endcase
			end
			cw.w.norm_x = n[0][15:0]; cw.w.norm_y = n[1][15:0]; cw.w.norm_z = n[2][15:0];
			cw.w.binorm_x = b[0][15:0]; cw.w.binorm_y = b[1][15:0];
			cw.w.binorm_z = b[2][15:0];
			cw.k = 2'(k);
			cw.l = (2'(k) == frcs_pkg::CORNER_LAST);
			corner_q.insert(corner_q.size(), cw);
		end
	endtask

	task automatic check_field(string nm, longint e, longint a);
		if (e != a) begin
			errors++;
			$display("%0t: mismatch %s expected %0d actual %0d", $time, nm, e, a);
		end
	endtask

	// input acceptance, prediction, output check and the cycle limit
	always @(posedge clk) begin
		corner_word_t e;
		frcs_pkg::out_word_t a;
		cyc <= cyc + 1;
		in_fire <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			samples_in++;
			frame_corners(frcs_pkg::item_t'(s_axis_tdata));
		end
		if (m_axis_tvalid && m_axis_tready) begin
			corners_seen++;
			a = frcs_pkg::out_word_t'(m_axis_tdata);
			if (corner_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected corner word, expected none actual %h", $time,
					m_axis_tdata);
			end else begin
				e = corner_q.pop_front();
				check_field("vertex_x", e.w.vertex_x, a.vertex_x);
				check_field("vertex_y", e.w.vertex_y, a.vertex_y);
				check_field("vertex_z", e.w.vertex_z, a.vertex_z);
				check_field("norm_x", e.w.norm_x, a.norm_x);
				check_field("norm_y", e.w.norm_y, a.norm_y);
				check_field("norm_z", e.w.norm_z, a.norm_z);
				check_field("binorm_x", e.w.binorm_x, a.binorm_x);
				check_field("binorm_y", e.w.binorm_y, a.binorm_y);
				check_field("binorm_z", e.w.binorm_z, a.binorm_z);
				check_field("corner", e.k, m_axis_tuser);
				check_field("last", e.l, m_axis_tlast);
			end
		end
		if (cyc > LIMIT_CYC) begin
			$display("timeout at cycle %0d", cyc);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// sample driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_fire) begin
			if (sample_q.size() > 0 && (calm || $urandom_range(0, 99) >= 25)) begin
				s_axis_tdata <= sample_q.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver ready, with one long hold-off while a burst is pending
	always @(negedge clk) begin
		if (hold_go && !held) begin
			held <= 1'b1;
			stall_left <= 3000;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(0, 99) >= 25);
		end
	end

	always @(posedge clk) calm <= (cyc >= 14000 && cyc < 24000);

	task automatic put_sample(longint px, longint py, longint pz, longint tx, longint ty,
		longint tz);
		frcs_pkg::item_t it;
		it.pos_x = px[31:0]; it.pos_y = py[31:0]; it.pos_z = pz[31:0];
		it.tan_x = tx[15:0]; it.tan_y = ty[15:0]; it.tan_z = tz[15:0];
		sample_q.insert(sample_q.size(), it);
	endtask

	task automatic drain();
		while (sample_q.size() != 0 || s_axis_tvalid || corner_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_width(logic [frcs_pkg::CFG_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		half_width = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic longint rnd_tan();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55) return longint'($signed(16'($urandom())));
		if (sel < 85) return longint'($urandom_range(0, 128)) - 64;
		if (sel < 95) return (sel[0]) ? 16384 : -16384;
		return 0;
	endfunction

	function automatic longint rnd_pos();
		if ($urandom_range(0, 99) < 20)
			return ($urandom_range(0, 1)) ? 64'sd2147483647 - $urandom_range(0, 40000)
				: -64'sd2147483648 + $urandom_range(0, 40000);
		return longint'($signed(32'($urandom())));
	endfunction

	task automatic random_burst(int count);
		longint tx, ty, tz;
		for (int j = 0; j < count; j++) begin
			tx = rnd_tan(); ty = rnd_tan(); tz = rnd_tan();
			// occasional tangent along (1,1,1) or zero
			if ($urandom_range(0, 99) < 4) begin ty = tx; tz = tx; end
			put_sample(rnd_pos(), rnd_pos(), rnd_pos(), tx, ty, tz);
		end
	endtask

	logic [frcs_pkg::CFG_W-1:0] widths[6];

	// reset, directed samples, then random phases over several half widths
	initial begin
		tri_t pb;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// zero tangent: zero frame, next sample seeds again
		put_sample(0, 0, 0, 0, 0, 0);
		// tangent along (1,1,1) seeds from the y axis
		put_sample(65536, -65536, 0, 9459, 9459, 9459);
		put_sample(0, 0, 0, 16384, 0, 0);
		put_sample(0, 0, 0, 0, 16384, 0);
		put_sample(0, 0, 0, 0, 0, 16384);
		put_sample(2147483647, -2147483648, 2147483647, 32767, -32768, 32767);
		put_sample(-2147483648, 2147483647, -1, -32768, -32768, 32767);
		put_sample(1, -1, 0, 1, -1, 1);
		drain();
		// tangent along the previous binormal: degenerate frame
		pb = last_binorm;
		put_sample(123456, 0, -123456, $signed(pb[0]), $signed(pb[1]), $signed(pb[2]));
		put_sample(0, 0, 0, 0, 11585, 11585);
		drain();
		// seed with the most negative tangent along (1,1,1)
		put_sample(0, 0, 0, 0, 0, 0);
		put_sample(0, 0, 0, -32768, -32768, -32768);
		random_burst(4);
		drain();

		widths[0] = 20'd0;
		widths[1] = 20'd655360;
		widths[2] = 20'hFFFFF;
		widths[3] = frcs_pkg::CFG_RESET;
		widths[4] = 20'($urandom());
		widths[5] = 20'($urandom_range(1, 70000));
		for (int ph = 0; ph < 6; ph++) begin
			write_width(widths[ph]);
			if (ph == 2) begin
				put_sample(2147483647, 2147483647, 2147483647, 16384, 16384, 0);
				put_sample(-2147483648, -2147483648, -2147483648, 0, 16384, -16384);
			end
			random_burst(32);
			// long receiver hold-off while this burst is being offered
			if (ph == 1) hold_go = 1'b1;
			drain();
		end

		$display("checked %0d samples and %0d corner words over %0d half widths",
			samples_in, corners_seen, 7);
		$display("covered seeding, degenerate frames, saturation and a long output stall");
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
